### src/lzw_code_stream_encoder_defines.svh
// Assertion macros shared by the encoder's checker
`ifndef LZW_CODE_STREAM_ENCODER_DEFINES_SVH
`define LZW_CODE_STREAM_ENCODER_DEFINES_SVH

// concurrent check, off while reset is asserted
`define LZW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define LZW_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/lzw_cse_pkg.sv
// Shared types, constants and hash function of the LZW code stream encoder
package lzw_cse_pkg;

	localparam int HASH_SLOTS = 8192;
	localparam int SLOT_W     = $clog2(HASH_SLOTS);
	localparam int EPOCH_W    = 4;
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
	localparam int ACC_W      = 19;
	localparam int FILL_W     = 5;

	localparam logic [11:0] CODE_CLEAR = 12'd256;
	localparam logic [11:0] CODE_END   = 12'd257;
	localparam logic [12:0] CODE_FIRST = 13'd258;
	localparam logic [12:0] CODE_TOP   = 13'd4095;
	localparam logic [3:0]  WIDTH_MIN  = 4'd9;
	localparam logic [3:0]  WIDTH_MAX  = 4'd12;

	typedef struct packed {
		logic [7:0] pix;
		logic       last;
		logic       first;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [19:0]        key;
		logic [11:0]        code;
	} entry_t;

	function automatic logic [SLOT_W-1:0] hash_slot(input logic [19:0] key);
		logic [22:0] h;
		h = {3'b000, key >> 5} ^ {key, 3'b000};
		return h[SLOT_W-1:0];
	endfunction

endpackage

### src/lzw_code_stream_encoder.sv
// GIF LZW encoder, 12-bit codes: pixel indices in, LSB-first packed code bytes out.
// A pixel that extends the current string takes a queue pop, then a read and a compare in
// the single-port dictionary RAM for each probe of the linear-probing chain. A pixel that
// ends a string also sends its codes and packs them into bytes; the last pixel of a frame
// sends up to seven bytes. The dictionary is emptied by stepping an epoch tag; after
// reset, and after every fifteenth dictionary clear, a clearing pass over all 8192 slots
// runs during which no pixel is taken. The output byte sits in a register of its own, so
// the engine keeps working while a byte waits, and a two-entry queue lets pixels arrive
// while the engine is busy.
module lzw_code_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  logic [7:0] pixel_index,
	input  logic       frame_last,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] data_byte,
	output logic       item_last,
	output logic       frame_end
);

	lzw_cse_pkg::q_stat_t q_stat;
	lzw_cse_pkg::item_t   push_item;
	lzw_cse_pkg::item_t   pop_item;
	logic push;
	logic pop;

	lzw_cse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_index (pixel_index),
		.frame_last  (frame_last),
		.q_stat      (q_stat),
		.push        (push),
		.push_item   (push_item)
	);

	lzw_cse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	lzw_cse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_item   (pop_item),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.item_last  (item_last),
		.frame_end  (frame_end)
	);

endmodule

### src/lzw_cse_front.sv
// Input side: takes pixels, tags the first pixel of each frame, pushes to the queue
module lzw_cse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  logic [7:0]          pixel_index,
	input  logic                frame_last,
	input  lzw_cse_pkg::q_stat_t q_stat,
	output logic                push,
	output lzw_cse_pkg::item_t  push_item
);

	logic in_frame_q;

	assign pixel_stall     = q_stat.full;
	assign push            = pixel_valid && !q_stat.full;
	assign push_item.pix   = pixel_index;
	assign push_item.last  = frame_last;
	assign push_item.first = !in_frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (push) begin
			in_frame_q <= !frame_last;
		end
	end

endmodule

### src/lzw_cse_fifo.sv
// Two-entry queue between the input side and the encode engine
module lzw_cse_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lzw_cse_pkg::item_t   push_item,
	input  logic                 pop,
	output lzw_cse_pkg::item_t   pop_item,
	output lzw_cse_pkg::q_stat_t q_stat
);

	lzw_cse_pkg::item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign pop_item     = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

### src/lzw_cse_back.sv
// Encode engine: dictionary probe, code emission, bit packing, output register
module lzw_cse_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lzw_cse_pkg::q_stat_t q_stat,
	input  lzw_cse_pkg::item_t   pop_item,
	output logic                 pop,
	output logic                 byte_valid,
	input  logic                 byte_stall,
	output logic [7:0]           data_byte,
	output logic                 item_last,
	output logic                 frame_end
);

	typedef enum logic [10:0] {
		S_CLR   = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_RD    = 11'b000_0000_0100,
		S_CMP   = 11'b000_0000_1000,
		S_SEND  = 11'b000_0001_0000,
		S_MISS  = 11'b000_0010_0000,
		S_FULL  = 11'b000_0100_0000,
		S_TAIL  = 11'b000_1000_0000,
		S_ENDC  = 11'b001_0000_0000,
		S_FLUSH = 11'b010_0000_0000,
		S_FIN   = 11'b100_0000_0000
	} state_t;

	lzw_cse_pkg::entry_t mem [lzw_cse_pkg::HASH_SLOTS];
	lzw_cse_pkg::entry_t rdata_q;

	state_t state_q;
	state_t ret_q;
	logic [7:0]  pix_q;
	logic        last_q;
	logic [11:0] prefix_q;
	logic [12:0] next_q;
	logic [3:0]  width_q;
	logic [lzw_cse_pkg::EPOCH_W-1:0] epoch_q;
	logic        wrap_q;
	logic [lzw_cse_pkg::SLOT_W-1:0] clr_cnt_q;
	logic [lzw_cse_pkg::SLOT_W-1:0] slot_q;
	logic [lzw_cse_pkg::ACC_W-1:0]  acc_q;
	logic [lzw_cse_pkg::FILL_W-1:0] fill_q;
	logic        pend_v_q;
	logic [7:0]  pend_q;
	logic        out_v_q;
	logic [7:0]  out_data_q;
	logic        out_il_q;
	logic        out_fe_q;

	logic        out_free;
	logic        byte_ok;
	logic        push_o;
	logic        push_il;
	logic        push_fe;
	logic        mem_we;
	logic [lzw_cse_pkg::SLOT_W-1:0] mem_wa;
	lzw_cse_pkg::entry_t mem_wd;
	logic [19:0] key;

	assign key      = {prefix_q, pix_q};
	assign out_free = !out_v_q || !byte_stall;
	assign byte_ok  = !pend_v_q || out_free;
	assign pop      = (state_q == S_IDLE) && !q_stat.empty;

	assign byte_valid = out_v_q;
	assign data_byte  = out_data_q;
	assign item_last  = out_il_q;
	assign frame_end  = out_fe_q;

	// a held byte moves to the output when a newer byte replaces it or the item ends
	always_comb begin
		push_o  = 1'b0;
		push_il = 1'b0;
		push_fe = 1'b0;
		unique case (state_q)
			S_SEND:  push_o = (fill_q >= 5'd8) && pend_v_q && out_free;
			S_FLUSH: push_o = (fill_q != '0) && pend_v_q && out_free;
			S_FIN: begin
				push_o  = pend_v_q && out_free;
				push_il = 1'b1;
				push_fe = last_q;
			end
			default: push_o = 1'b0;
		endcase
	end

	always_comb begin
		mem_we = (state_q == S_CLR) ||
			((state_q == S_MISS) && (next_q <= lzw_cse_pkg::CODE_TOP));
		mem_wa = (state_q == S_CLR) ? clr_cnt_q : slot_q;
		if (state_q == S_CLR) begin
			mem_wd = '0;
		end else begin
			mem_wd.tag  = epoch_q;
			mem_wd.key  = key;
			mem_wd.code = next_q[11:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == S_RD) begin
			rdata_q <= mem[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (push_o) begin
			out_data_q <= pend_q;
			out_il_q   <= push_il;
			out_fe_q   <= push_fe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_o) begin
			out_v_q <= 1'b1;
		end else if (!byte_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			ret_q     <= S_FIN;
			pix_q     <= '0;
			last_q    <= 1'b0;
			prefix_q  <= '0;
			next_q    <= lzw_cse_pkg::CODE_FIRST;
			width_q   <= lzw_cse_pkg::WIDTH_MIN;
			epoch_q   <= lzw_cse_pkg::EPOCH_W'(1);
			wrap_q    <= 1'b0;
			clr_cnt_q <= '0;
			slot_q    <= '0;
			acc_q     <= '0;
			fill_q    <= '0;
			pend_v_q  <= 1'b0;
			pend_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (!q_stat.empty) begin
						pix_q  <= pop_item.pix;
						last_q <= pop_item.last;
						if (pop_item.first) begin
							// new frame: empty dictionary by moving to a fresh epoch
							if (epoch_q == lzw_cse_pkg::EPOCH_MAX) begin
								epoch_q <= lzw_cse_pkg::EPOCH_W'(1);
								wrap_q  <= 1'b1;
							end else begin
								epoch_q <= epoch_q + 1'b1;
							end
							width_q  <= lzw_cse_pkg::WIDTH_MIN;
							next_q   <= lzw_cse_pkg::CODE_FIRST;
							acc_q    <= lzw_cse_pkg::ACC_W'(lzw_cse_pkg::CODE_CLEAR);
							fill_q   <= lzw_cse_pkg::FILL_W'(lzw_cse_pkg::WIDTH_MIN);
							prefix_q <= 12'(pop_item.pix);
							ret_q    <= S_TAIL;
							state_q  <= S_SEND;
						end else begin
							slot_q  <= lzw_cse_pkg::hash_slot({prefix_q, pop_item.pix});
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (rdata_q.tag == epoch_q) begin
						if (rdata_q.key == key) begin
							prefix_q <= rdata_q.code;
							state_q  <= S_TAIL;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						acc_q   <= acc_q | (lzw_cse_pkg::ACC_W'(prefix_q) << fill_q[2:0]);
						fill_q  <= fill_q + lzw_cse_pkg::FILL_W'(width_q);
						ret_q   <= S_MISS;
						state_q <= S_SEND;
					end
				end
				S_MISS: begin
					if (next_q <= lzw_cse_pkg::CODE_TOP) begin
						if ((next_q == (13'd1 << width_q)) && (width_q < lzw_cse_pkg::WIDTH_MAX))
							width_q <= width_q + 4'd1;
						next_q   <= next_q + 13'd1;
						prefix_q <= 12'(pix_q);
						state_q  <= S_TAIL;
					end else begin
						acc_q   <= acc_q |
							(lzw_cse_pkg::ACC_W'(lzw_cse_pkg::CODE_CLEAR) << fill_q[2:0]);
						fill_q  <= fill_q + lzw_cse_pkg::FILL_W'(width_q);
						ret_q   <= S_FULL;
						state_q <= S_SEND;
					end
				end
				S_FULL: begin
					if (epoch_q == lzw_cse_pkg::EPOCH_MAX) begin
						epoch_q <= lzw_cse_pkg::EPOCH_W'(1);
						wrap_q  <= 1'b1;
					end else begin
						epoch_q <= epoch_q + 1'b1;
					end
					width_q  <= lzw_cse_pkg::WIDTH_MIN;
					next_q   <= lzw_cse_pkg::CODE_FIRST;
					prefix_q <= 12'(pix_q);
					state_q  <= S_TAIL;
				end
				S_TAIL: begin
					if (last_q) begin
						acc_q   <= acc_q | (lzw_cse_pkg::ACC_W'(prefix_q) << fill_q[2:0]);
						fill_q  <= fill_q + lzw_cse_pkg::FILL_W'(width_q);
						ret_q   <= S_ENDC;
						state_q <= S_SEND;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_ENDC: begin
					acc_q   <= acc_q | (lzw_cse_pkg::ACC_W'(lzw_cse_pkg::CODE_END) << fill_q[2:0]);
					fill_q  <= fill_q + lzw_cse_pkg::FILL_W'(width_q);
					ret_q   <= S_FLUSH;
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (fill_q >= 5'd8) begin
						if (byte_ok) begin
							pend_q   <= acc_q[7:0];
							pend_v_q <= 1'b1;
							acc_q    <= acc_q >> 8;
							fill_q   <= fill_q - 5'd8;
						end
					end else begin
						state_q <= ret_q;
					end
				end
				S_FLUSH: begin
					if (fill_q == '0) begin
						state_q <= S_FIN;
					end else if (byte_ok) begin
						pend_q   <= acc_q[7:0];
						pend_v_q <= 1'b1;
						acc_q    <= '0;
						fill_q   <= '0;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (!pend_v_q || out_free) begin
						pend_v_q  <= 1'b0;
						wrap_q    <= 1'b0;
						clr_cnt_q <= '0;
						state_q   <= wrap_q ? S_CLR : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### src/lzw_cse_chk.sv
// Port-level checker for the LZW code stream encoder, bound to the top level
`include "lzw_code_stream_encoder_defines.svh"

module lzw_cse_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       pixel_valid,
	input logic       pixel_stall,
	input logic [7:0] pixel_index,
	input logic       frame_last,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] data_byte,
	input logic       item_last,
	input logic       frame_end
);

	`LZW_ASSERT(a_in_hold, clk, arst_n, pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_index) && $stable(frame_last), "input transaction changed while stalled")
	`LZW_ASSERT(a_out_hold, clk, arst_n, byte_valid && byte_stall |=> byte_valid && $stable(data_byte) && $stable(item_last) && $stable(frame_end), "output transaction changed while stalled")
	`LZW_ASSERT(a_end_is_last, clk, arst_n, byte_valid && frame_end |-> item_last, "frame end byte not marked as last of its pixel")
	`LZW_ASSERT_RST(a_rst_quiet, clk, !arst_n |-> !byte_valid, "output valid during reset")

endmodule

bind lzw_code_stream_encoder lzw_cse_chk u_chk (.*);

### tb/lzw_code_stream_encoder_checker.sv
// Transaction monitor, byte stream predictor and comparator for the LZW code stream encoder
`timescale 1ns / 100ps

module lzw_code_stream_encoder_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	input  logic       pixel_stall,
	input  logic [7:0] pixel_index,
	input  logic       frame_last,
	input  logic       byte_valid,
	input  logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       item_last,
	input  logic       frame_end,
	output int         fail_count,
	output int         bytes_pending
);

	typedef struct packed {
		logic [7:0] data;
		logic       ilast;
		logic       fend;
	} coded_byte_t;

	coded_byte_t byte_fifo[$];
	coded_byte_t step_bytes[$];

	// predictor state; the dictionary is keyed directly by {prefix, pixel}
	logic [11:0] string_dict[logic [19:0]];
	logic [11:0] prefix_code;
	logic [12:0] free_code;
	logic [3:0]  width;
	logic [6:0]  hold_bits;
	logic [2:0]  hold_count;
	logic        frame_open;

	assign bytes_pending = byte_fifo.size();

	function automatic void pack_code(input logic [11:0] code);
		logic [31:0] acc;
		int          fill;
		acc  = 32'(hold_bits) | (32'(code) << hold_count);
		fill = int'(hold_count) + int'(width);
		while (fill >= 8) begin
			step_bytes.push_back('{acc[7:0], 1'b0, 1'b0});
			acc  = acc >> 8;
			fill -= 8;
		end
		hold_bits  = acc[6:0];
		hold_count = 3'(fill);
	endfunction

	function automatic void empty_dict();
		string_dict.delete();
		width     = lzw_cse_pkg::WIDTH_MIN;
		free_code = lzw_cse_pkg::CODE_FIRST;
	endfunction

	function automatic void encode_pixel(input logic [7:0] pix, input logic last);
		logic [19:0] key;
		step_bytes.delete();
		if (!frame_open) begin
			empty_dict();
			hold_bits  = '0;
			hold_count = '0;
			pack_code(lzw_cse_pkg::CODE_CLEAR);
			prefix_code = {4'd0, pix};
			frame_open  = 1'b1;
		end else begin
			key = {prefix_code, pix};
			if (string_dict.exists(key)) begin
				prefix_code = string_dict[key];
			end else begin
				pack_code(prefix_code);
				if (free_code <= lzw_cse_pkg::CODE_TOP) begin
					string_dict[key] = free_code[11:0];
					if (free_code == (13'd1 << width) && width < lzw_cse_pkg::WIDTH_MAX)
						width++;
					free_code++;
				end else begin
					// table full: clear code at the current width, pair dropped
					pack_code(lzw_cse_pkg::CODE_CLEAR);
					empty_dict();
				end
				prefix_code = {4'd0, pix};
			end
		end
		if (last) begin
			pack_code(prefix_code);
			pack_code(lzw_cse_pkg::CODE_END);
			if (hold_count != 0)
				step_bytes.push_back('{{1'b0, hold_bits}, 1'b0, 1'b0});
			hold_bits  = '0;
			hold_count = '0;
			frame_open = 1'b0;
		end
		if (step_bytes.size() > 0) begin
			step_bytes[$].ilast = 1'b1;
			step_bytes[$].fend  = last;
		end
		foreach (step_bytes[i])
			byte_fifo.push_back(step_bytes[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		coded_byte_t want;
		if (!arst_n) begin
			fail_count  = 0;
			byte_fifo.delete();
			string_dict.delete();
			prefix_code = '0;
			free_code   = lzw_cse_pkg::CODE_FIRST;
			width       = lzw_cse_pkg::WIDTH_MIN;
			hold_bits   = '0;
			hold_count  = '0;
			frame_open  = 1'b0;
		end else begin
			if (byte_valid && !byte_stall) begin
				if (byte_fifo.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected byte %02h last=%b end=%b", $realtime,
							data_byte, item_last, frame_end);
				end else begin
					want = byte_fifo.pop_front();
					if (want.data != data_byte || want.ilast != item_last
							|| want.fend != frame_end) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: byte mismatch exp %02h/%b/%b got %02h/%b/%b",
								$realtime, want.data, want.ilast, want.fend,
								data_byte, item_last, frame_end);
					end
				end
			end
			if (pixel_valid && !pixel_stall)
				encode_pixel(pixel_index, frame_last);
		end
	end

endmodule

### tb/lzw_code_stream_encoder_test.sv
// Stimulus, handshake idling and verdict for the LZW code stream encoder
`timescale 1ns / 100ps

module lzw_code_stream_encoder_test;
	localparam int IDLE_LIMIT = 60000;

	logic       clk;
	logic       arst_n;
	logic       pixel_valid;
	logic       pixel_stall;
	logic [7:0] pixel_index;
	logic       frame_last;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] data_byte;
	logic       item_last;
	logic       frame_end;
	int         fail_count;
	int         bytes_pending;
	logic       quiet;
	int         idle_cycles;

	lzw_code_stream_encoder i_dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
		.pixel_index(pixel_index), .frame_last(frame_last),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.data_byte(data_byte), .item_last(item_last), .frame_end(frame_end)
	);

	lzw_code_stream_encoder_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
		.pixel_index(pixel_index), .frame_last(frame_last),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.data_byte(data_byte), .item_last(item_last), .frame_end(frame_end),
		.fail_count(fail_count), .bytes_pending(bytes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stall bursts
	initial begin
		byte_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				byte_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				byte_stall <= 1'b0;
			end
		end
	end

	// watchdog on handshake activity; covers the clearing pass after reset
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (byte_valid && !byte_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_pixel(input logic [7:0] pix, input logic last);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_index <= pix;
		frame_last  <= last;
		do @(posedge clk); while (pixel_stall);
	endtask

	// palette_bits limits the index range so strings repeat and hit the dictionary
	task automatic send_frame(input int len, input int palette_bits);
		logic [7:0] base;
		base = 8'($urandom);
		for (int i = 0; i < len; i++)
			send_pixel(base ^ 8'($urandom_range(0, (1 << palette_bits) - 1)), i == len - 1);
	endtask

	task automatic drain_bytes();
		pixel_valid <= 1'b0;
		while (bytes_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int sent;
		int len;
		arst_n      = 1'b0;
		pixel_valid = 1'b0;
		pixel_index = '0;
		frame_last  = 1'b0;
		quiet       = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// one-pixel frames at both extremes
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b1);
		// a run of one value: hits, growing strings
		for (int i = 0; i < 10; i++) send_pixel(8'hAA, i == 9);
		// alternating extremes
		for (int i = 0; i < 8; i++) send_pixel(i[0] ? 8'hFF : 8'h00, i == 7);
		drain_bytes();

		sent = 0;
		while (sent < 165) begin
			len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
			send_frame(len, $urandom_range(0, 8));
			sent += len;
		end
		drain_bytes();

		quiet <= 1'b1;
		for (int i = 0; i < 6; i++) send_frame($urandom_range(1, 12), $urandom_range(1, 3));
		pixel_valid <= 1'b0;

		while (bytes_pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
